[design/masg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_pkg
// Shared types and constants of the multi-axis step generator.
// ----------------------------------------------------------------------------
package masg_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int AXES_DEF        = 4;
    // axes that have a count field in the request
    localparam int IN_AXES         = 4;
    localparam int DIR_WIDTH       = 4;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef struct packed {
        logic load;
        logic tick;
    } t_axis_cmd;

    typedef struct packed {
        logic pulse;
        logic left;
    } t_axis_stat;

endpackage
`default_nettype wire

[design/masg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_in_if
// Request channel: a move load or a step tick.
// ----------------------------------------------------------------------------
interface masg_in_if #(
    parameter int COUNT_WIDTH = masg_pkg::COUNT_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [COUNT_WIDTH-1:0]         count_x;
    logic [COUNT_WIDTH-1:0]         count_y;
    logic [COUNT_WIDTH-1:0]         count_z;
    logic [COUNT_WIDTH-1:0]         count_e;
    logic [COUNT_WIDTH-1:0]         tick_total;
    logic [masg_pkg::DIR_WIDTH-1:0] dir_bits;

    modport source (
        output valid, func, count_x, count_y, count_z, count_e, tick_total, dir_bits,
        input  ready
    );
    modport sink (
        input  valid, func, count_x, count_y, count_z, count_e, tick_total, dir_bits,
        output ready
    );
endinterface
`default_nettype wire

[design/masg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_out_if
// Result channel: step pulses and move status for each request.
// ----------------------------------------------------------------------------
interface masg_out_if #(
    parameter int COUNT_WIDTH = masg_pkg::COUNT_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           pulse_x;
    logic                           pulse_y;
    logic                           pulse_z;
    logic                           pulse_e;
    logic [masg_pkg::DIR_WIDTH-1:0] dir_out;
    logic                           busy_res;
    logic                           move_done;
    logic [COUNT_WIDTH-1:0]         tick_index;

    modport source (
        output valid, pulse_x, pulse_y, pulse_z, pulse_e, dir_out, busy_res, move_done,
               tick_index,
        input  ready
    );
    modport sink (
        input  valid, pulse_x, pulse_y, pulse_z, pulse_e, dir_out, busy_res, move_done,
               tick_index,
        output ready
    );
endinterface
`default_nettype wire

[design/masg_axis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_axis
// One Bresenham axis: error accumulator, remaining steps and step decision.
// ----------------------------------------------------------------------------
module masg_axis #(
    parameter int COUNT_WIDTH = masg_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire masg_pkg::t_axis_cmd    i_cmd,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire logic [COUNT_WIDTH-1:0] i_total,
    output masg_pkg::t_axis_stat        o_stat
);

    localparam int ERR_WIDTH = COUNT_WIDTH + 2;

    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [ERR_WIDTH-1:0]   r_err;
    // total minus count, so the step branch is a single add
    logic [ERR_WIDTH-1:0]   r_diff;

    logic [COUNT_WIDTH-1:0] n_rem;
    logic [ERR_WIDTH-1:0]   w_sub;
    logic [ERR_WIDTH-1:0]   w_half;
    logic [ERR_WIDTH-1:0]   w_preset;
    logic                   w_has;
    logic                   w_neg;
    logic                   w_step;

    assign w_has    = (r_rem != '0);
    assign w_sub    = r_err - {2'b00, r_count};
    assign w_neg    = w_sub[ERR_WIDTH-1];
    assign w_step   = i_cmd.tick && w_has && w_neg;
    assign n_rem    = w_step ? (r_rem - 1'b1) : r_rem;
    assign w_half   = {3'b000, i_total[COUNT_WIDTH-1:1]};
    assign w_preset = {ERR_WIDTH{1'b0}} - w_half;

    assign o_stat.pulse = w_step;
    assign o_stat.left  = (n_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_count <= '0;
            r_err   <= '0;
            r_diff  <= '0;
        end else if (i_cmd.load) begin
            r_rem   <= i_count;
            r_count <= i_count;
            r_err   <= w_preset;
            r_diff  <= {2'b00, i_total} - {2'b00, i_count};
        end else if (i_cmd.tick && w_has) begin
            r_err   <= w_neg ? (r_err + r_diff) : w_sub;
            r_rem   <= n_rem;
        end
    end

endmodule
`default_nettype wire

[design/masg_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_skid
// Output register with a skid entry; ready upstream is a register.
// ----------------------------------------------------------------------------
module masg_skid #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_in_fire;
    logic             w_out_fire;

    assign o_ready    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_fire;
                r_out_data   <= i_data;
            end
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule
`default_nettype wire

[design/multi_axis_step_generator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_axis_step_generator_core
// Multi-axis Bresenham step generator.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests. func = load presets a move from the per-axis
//   counts, tick_total and dir_bits; a zero total cancels any move. func =
//   tick advances the active move by one step period. Each request yields
//   exactly one result on o_out: the pulses of the tick, the latched
//   directions, busy after the request, done when the tick ended the move,
//   and the tick index within the move.
//   The result is registered in the output register. One request is accepted
//   per cycle while i_in.ready is high; each tick is a subtract, sign test
//   and add per axis, done in parallel in the axis units.
//   The result register is backed by a skid entry: while the receiver stalls
//   one more request is taken, then i_in.ready drops until the output drains.
//   Synchronous reset clears the move state (idle, directions and tick
//   count zero) and empties the output; no result is pending after reset.
// ----------------------------------------------------------------------------
module multi_axis_step_generator_core #(
    parameter int COUNT_WIDTH = masg_pkg::COUNT_WIDTH_DEF,
    parameter int AXES        = masg_pkg::AXES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    masg_in_if.sink   i_in,
    masg_out_if.source o_out
);

    localparam int IN_AXES  = masg_pkg::IN_AXES;
    localparam int DIR_W    = masg_pkg::DIR_WIDTH;
    localparam int RES_W    = IN_AXES + DIR_W + 2 + COUNT_WIDTH;

    logic                   r_active;
    logic [DIR_W-1:0]       r_dir;
    logic [COUNT_WIDTH-1:0] r_tick;

    logic                   n_active;
    logic [DIR_W-1:0]       n_dir;
    logic [COUNT_WIDTH-1:0] n_tick;

    logic                   w_ready;
    logic                   w_accept;
    masg_pkg::t_func        w_func;
    logic                   w_load_go;
    logic                   w_null_go;
    logic                   w_tick_go;
    logic                   w_any_left;
    logic                   w_done;
    masg_pkg::t_axis_cmd    w_cmd;
    masg_pkg::t_axis_stat   w_stat  [AXES];
    logic [AXES-1:0]        w_left;
    logic [IN_AXES-1:0]     w_pulse;
    logic [COUNT_WIDTH-1:0] w_count_in [IN_AXES];
    logic [RES_W-1:0]       w_res;
    logic [RES_W-1:0]       w_res_out;

    assign w_count_in[0] = i_in.count_x;
    assign w_count_in[1] = i_in.count_y;
    assign w_count_in[2] = i_in.count_z;
    assign w_count_in[3] = i_in.count_e;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;
    assign w_func     = masg_pkg::t_func'(i_in.func);
    assign w_load_go  = w_accept && (w_func == masg_pkg::FUNC_LOAD) && (i_in.tick_total != '0);
    assign w_null_go  = w_accept && (w_func == masg_pkg::FUNC_LOAD) && (i_in.tick_total == '0);
    assign w_tick_go  = w_accept && (w_func == masg_pkg::FUNC_TICK) && r_active;

    assign w_cmd.load = w_load_go;
    assign w_cmd.tick = w_tick_go;

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_axis
            logic [COUNT_WIDTH-1:0] w_cnt;
            if (g < IN_AXES) begin : g_fed
                assign w_cnt = w_count_in[g];
            end else begin : g_unfed
                assign w_cnt = '0;
            end
            masg_axis #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_axis (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_count (w_cnt),
                .i_total (i_in.tick_total),
                .o_stat  (w_stat[g])
            );
            assign w_left[g] = w_stat[g].left;
        end
        for (g = 0; g < IN_AXES; g++) begin : g_pulse
            if (g < AXES) begin : g_on
                assign w_pulse[g] = w_stat[g].pulse;
            end else begin : g_off
                assign w_pulse[g] = 1'b0;
            end
        end
    endgenerate

    assign w_any_left = |w_left;
    assign w_done     = w_tick_go && !w_any_left;

    always_comb begin
        n_active = r_active;
        n_dir    = r_dir;
        n_tick   = r_tick;
        if (w_load_go) begin
            n_active = 1'b1;
            n_dir    = i_in.dir_bits;
            n_tick   = '0;
        end else if (w_null_go) begin
            n_active = 1'b0;
        end else if (w_tick_go) begin
            n_active = w_any_left;
            n_tick   = r_tick + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dir    <= '0;
            r_tick   <= '0;
        end else begin
            r_active <= n_active;
            r_dir    <= n_dir;
            r_tick   <= n_tick;
        end
    end

    assign w_res = {w_pulse, n_dir, n_active, w_done, n_tick};

    masg_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_ready (w_ready),
        .i_data  (w_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_res_out)
    );

    assign o_out.pulse_e    = w_res_out[RES_W-1];
    assign o_out.pulse_z    = w_res_out[RES_W-2];
    assign o_out.pulse_y    = w_res_out[RES_W-3];
    assign o_out.pulse_x    = w_res_out[RES_W-4];
    assign o_out.dir_out    = w_res_out[COUNT_WIDTH+2+:DIR_W];
    assign o_out.busy_res   = w_res_out[COUNT_WIDTH+1];
    assign o_out.move_done  = w_res_out[COUNT_WIDTH];
    assign o_out.tick_index = w_res_out[COUNT_WIDTH-1:0];

endmodule
`default_nettype wire

[design/masg_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masg_chk
// Port-level checks of the step generator, bound to the top level.
// ----------------------------------------------------------------------------
module masg_chk #(
    parameter int COUNT_WIDTH = masg_pkg::COUNT_WIDTH_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [3:0]             i_pulses,
    input wire logic [3:0]             i_dir_out,
    input wire logic                   i_busy,
    input wire logic                   i_done,
    input wire logic [COUNT_WIDTH-1:0] i_tick_index
);

    // a finished move never reports busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> !i_busy)
        else $error("move_done with busy_res set");

    // no pulses on results that neither run nor end a move
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_busy && !i_done |-> (i_pulses == 4'b0000))
        else $error("pulse while idle");

    // request side only backs up behind a stalled result
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("request stalled with output empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pulses)
            && $stable(i_dir_out) && $stable(i_busy) && $stable(i_done)
            && $stable(i_tick_index))
        else $error("stalled result changed");

endmodule

bind multi_axis_step_generator_core masg_chk #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_masg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_pulses     ({o_out.pulse_e, o_out.pulse_z, o_out.pulse_y, o_out.pulse_x}),
    .i_dir_out    (o_out.dir_out),
    .i_busy       (o_out.busy_res),
    .i_done       (o_out.move_done),
    .i_tick_index (o_out.tick_index)
);
`default_nettype wire
